FILE: rtl/core/hid_frame_reassembler_defines.svh
// ----------------------------------------------------------------------------
// HID frame reassembler assertion macros
// Concurrent checks used by the reassembler RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef HID_FRAME_REASSEMBLER_DEFINES_SVH
`define HID_FRAME_REASSEMBLER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is low
`define HIDFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hidfr: same-cycle check failed");
// Next-cycle implication, disabled while reset is low
`define HIDFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hidfr: next-cycle check failed");
`else
`define HIDFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HIDFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/hidfr_pkg.sv
// ----------------------------------------------------------------------------
// HID frame reassembler package
// Shared types, register map and report layout constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hidfr_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_CHANNEL_ID = 1'b0;
    localparam logic [0:0] REG_MAX_LEN    = 1'b1;
    localparam logic [31:0] CHANNEL_ID_RST = 32'hFF00_0000;
    localparam logic [15:0] MAX_LEN_RST    = 16'd5120;

    // Report layout
    localparam int CHAN_BYTES   = 4;
    localparam int POS_TYPE     = 4;
    localparam int POS_COUNT_HI = 5;
    localparam int POS_COUNT_LO = 6;
    localparam int POS_ERR_CODE = 7;
    localparam logic [7:0] TYPE_INIT_BIT = 8'h80;
    localparam logic [7:0] CMD_ERROR     = 8'hBF;
    localparam logic [6:0] SEQ_MASK      = 7'h7F;

    // Result status codes
    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_DEVERR  = 2'd1;
    localparam logic [1:0] ST_BADSEQ  = 2'd2;
    localparam logic [1:0] ST_LINK    = 2'd3;

    // What to do with the rest of the current report
    typedef enum logic [1:0] {
        ACT_UNDECIDED = 2'd0,
        ACT_SKIP      = 2'd1,
        ACT_ERROR     = 2'd2,
        ACT_MESSAGE   = 2'd3
    } t_action;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [31:0] channel_id;
        logic [15:0] max_len;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/core/hid_frame_reassembler.sv
// ----------------------------------------------------------------------------
// HID frame reassembler
// Rebuilds one message from a byte stream of HID reports on one channel.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one report byte per item in tdata, frame_start and
//   link_fail flags in tuser. Master stream: one result item per report
//   byte that produces one (payload byte, device error, invalid sequence,
//   link failure); tlast marks the item that ends or aborts the message.
//   Registers channel_id (0x0) and max_len (0x4) on the APB port must be
//   written while the stream is idle; the block does not enforce this.
//   An item accepted on the slave stream lands in the input register,
//   is decoded into the output register, and its result is presented
//   from there on the master stream.
//   Throughput: one byte per cycle unless a result waits on the master
//   side; the decode is a single pass between the input and output registers.
//   Reset (synchronous, active low) empties both registers, returns to
//   hunting for an init report and loads the register defaults.
//   When the master side stalls, the input register keeps taking items
//   that produce no result; an item with a result waits until the output
//   register frees, and tready drops while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hid_frame_reassembler_defines.svh"

module hid_frame_reassembler #(
    parameter int REPORT_BYTES = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Slave stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [7:0]                       i_s_axis_tdata,  // [7:0] rx_byte
    input  wire logic [1:0]                       i_s_axis_tuser,  // [0] frame_start, [1] link_fail
    // Master stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [23:0]                           o_m_axis_tdata,  // [7:0] out_byte, [23:8] msg_len
    output logic [2:0]                            o_m_axis_tuser,  // [0] has_byte, [2:1] status
    output logic                                  o_m_axis_tlast,
    // Configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [hidfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [hidfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [hidfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                  pready
);
    import hidfr_pkg::*;

    localparam int POS_W = $clog2(REPORT_BYTES);

    t_cfg w_cfg;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_in_fail;

    // Reassembly state
    logic [POS_W-1:0] r_pos,         n_pos;
    logic             r_receiving,   n_receiving;
    t_action          r_action,      n_action;
    logic [31:0]      r_chan,        n_chan;
    logic [7:0]       r_count_high,  n_count_high;
    logic [15:0]      r_bytes_left,  n_bytes_left;
    logic [15:0]      r_deliv_len,   n_deliv_len;
    logic [7:0]       r_exp_seq,     n_exp_seq;

    // Output register
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_has;
    logic [1:0]  r_out_status;
    logic        r_out_last;
    logic [15:0] r_out_len;

    // Decode results
    logic             w_res_valid;
    logic [7:0]       w_res_byte;
    logic             w_res_has;
    logic [1:0]       w_res_status;
    logic             w_res_last;
    logic [15:0]      w_res_len;
    logic [POS_W-1:0] w_pos;
    logic [POS_W:0]   w_pos_inc;
    t_action          w_action;
    logic             w_same;
    logic [15:0]      w_count;
    logic [15:0]      w_limited;
    logic [15:0]      w_left_dec;
    logic             w_out_free;
    logic             w_fire;

    hidfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake: decode the held item when it has no result or its result has somewhere to go
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_fire          = r_in_valid && (!w_res_valid || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    // Capture incoming items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte  <= i_s_axis_tdata;
            r_in_start <= i_s_axis_tuser[0];
            r_in_fail  <= i_s_axis_tuser[1];
        end
    end

    // Per-byte helpers
    assign w_pos      = r_in_start ? '0 : r_pos;
    assign w_pos_inc  = {1'b0, w_pos} + (POS_W+1)'(1);
    assign w_action   = (w_pos == '0) ? ACT_UNDECIDED : r_action;
    assign w_same     = (r_chan == w_cfg.channel_id);
    assign w_count    = {r_count_high, r_in_byte};
    assign w_limited  = (w_count > w_cfg.max_len) ? w_cfg.max_len : w_count;
    assign w_left_dec = r_bytes_left - 16'd1;

    // Decode one report byte
    always_comb begin
        n_pos        = r_pos;
        n_receiving  = r_receiving;
        n_action     = w_action;
        n_chan       = r_chan;
        n_count_high = r_count_high;
        n_bytes_left = r_bytes_left;
        n_deliv_len  = r_deliv_len;
        n_exp_seq    = r_exp_seq;
        w_res_valid  = 1'b0;
        w_res_byte   = 8'd0;
        w_res_has    = 1'b0;
        w_res_status = ST_PAYLOAD;
        w_res_last   = 1'b0;
        w_res_len    = 16'd0;

        if (r_in_fail) begin
            // Abort on link failure and restart the report
            n_receiving  = 1'b0;
            n_action     = ACT_UNDECIDED;
            n_pos        = '0;
            w_res_valid  = 1'b1;
            w_res_status = ST_LINK;
            w_res_last   = 1'b1;
        end else begin
            // Advance the position, wrapping after a full report
            n_pos = (w_pos_inc >= (POS_W+1)'(REPORT_BYTES)) ? '0 : w_pos_inc[POS_W-1:0];

            if (w_pos < POS_W'(CHAN_BYTES)) begin
                // Shift in the big-endian channel id
                n_chan = {r_chan[23:0], r_in_byte};
            end else if (w_pos == POS_W'(POS_TYPE)) begin
                if (!r_receiving) begin
                    // Hunting: look for an init report on our channel
                    if (!w_same || (r_in_byte & TYPE_INIT_BIT) == 8'd0) begin
                        n_action = ACT_SKIP;
                    end else if (r_in_byte == CMD_ERROR) begin
                        n_action = ACT_ERROR;
                    end else begin
                        n_action    = ACT_MESSAGE;
                        n_receiving = 1'b1;
                        n_exp_seq   = 8'd0;
                    end
                end else if (!w_same) begin
                    n_action = ACT_SKIP;
                end else if (r_in_byte[7] || ({1'b0, r_in_byte[6:0] & SEQ_MASK} != r_exp_seq)) begin
                    // Drop the message on a bad continuation
                    n_receiving  = 1'b0;
                    n_action     = ACT_SKIP;
                    w_res_valid  = 1'b1;
                    w_res_status = ST_BADSEQ;
                    w_res_last   = 1'b1;
                end else begin
                    n_exp_seq = r_exp_seq + 8'd1;
                    n_action  = ACT_MESSAGE;
                end
            end else if (w_action == ACT_ERROR) begin
                // Device error report: deliver the error code
                if (w_pos == POS_W'(POS_ERR_CODE)) begin
                    n_action     = ACT_SKIP;
                    w_res_valid  = 1'b1;
                    w_res_byte   = r_in_byte;
                    w_res_has    = 1'b1;
                    w_res_status = ST_DEVERR;
                    w_res_last   = 1'b1;
                end
            end else if (w_action == ACT_MESSAGE) begin
                if (r_exp_seq == 8'd0 && w_pos == POS_W'(POS_COUNT_HI)) begin
                    n_count_high = r_in_byte;
                end else if (r_exp_seq == 8'd0 && w_pos == POS_W'(POS_COUNT_LO)) begin
                    // Load the limited byte count
                    n_bytes_left = w_limited;
                    n_deliv_len  = w_limited;
                    if (w_limited == 16'd0) begin
                        n_receiving = 1'b0;
                        n_action    = ACT_SKIP;
                        w_res_valid = 1'b1;
                        w_res_last  = 1'b1;
                    end
                end else if (r_bytes_left == 16'd0) begin
                    n_action = ACT_SKIP;
                end else begin
                    // Emit one payload byte
                    n_bytes_left = w_left_dec;
                    w_res_valid  = 1'b1;
                    w_res_byte   = r_in_byte;
                    w_res_has    = 1'b1;
                    if (w_left_dec == 16'd0) begin
                        n_receiving = 1'b0;
                        n_action    = ACT_SKIP;
                        w_res_last  = 1'b1;
                        w_res_len   = r_deliv_len;
                    end
                end
            end
        end
    end

    // Update state when the held item is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_receiving  <= 1'b0;
            r_action     <= ACT_UNDECIDED;
            r_chan       <= 32'd0;
            r_count_high <= 8'd0;
            r_bytes_left <= 16'd0;
            r_deliv_len  <= 16'd0;
            r_exp_seq    <= 8'd0;
        end else if (w_fire) begin
            r_pos        <= n_pos;
            r_receiving  <= n_receiving;
            r_action     <= n_action;
            r_chan       <= n_chan;
            r_count_high <= n_count_high;
            r_bytes_left <= n_bytes_left;
            r_deliv_len  <= n_deliv_len;
            r_exp_seq    <= n_exp_seq;
        end
    end

    // Output register: load a new result or drain the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out_byte   <= w_res_byte;
            r_out_has    <= w_res_has;
            r_out_status <= w_res_status;
            r_out_last   <= w_res_last;
            r_out_len    <= w_res_len;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_len, r_out_byte};
    assign o_m_axis_tuser  = {r_out_status, r_out_has};
    assign o_m_axis_tlast  = r_out_last;

    // Only payload bytes may leave a message open
    `HIDFR_ASSERT_IMP(a_open_is_payload, i_clk, i_rst_n, r_out_valid && !r_out_last, r_out_status == ST_PAYLOAD && r_out_has)
    // A non-final result leaves the block receiving
    `HIDFR_ASSERT_NXT(a_open_keeps_rx, i_clk, i_rst_n, w_fire && w_res_valid && !w_res_last, r_receiving)
    // Never overwrite a result the receiver has not taken
    `HIDFR_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_m_axis_tready && w_res_valid, !w_fire)
    // Device error reports are only seen while hunting
    `HIDFR_ASSERT_IMP(a_err_hunting, i_clk, i_rst_n, r_action == ACT_ERROR, !r_receiving)
    // A length is reported only on a closing payload result
    `HIDFR_ASSERT_IMP(a_len_on_close, i_clk, i_rst_n, r_out_valid && r_out_len != 16'd0, r_out_last && r_out_status == ST_PAYLOAD)

endmodule

`default_nettype wire

FILE: rtl/core/hidfr_regs.sv
// ----------------------------------------------------------------------------
// HID frame reassembler configuration registers
// APB-style register file holding the channel id and the length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module hidfr_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [hidfr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [hidfr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [hidfr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                  pready,
    output hidfr_pkg::t_cfg                       o_cfg
);
    import hidfr_pkg::*;

    logic [31:0] r_channel_id;
    logic [15:0] r_max_len;
    logic        w_wr;
    logic [0:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[2:2];

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_id <= CHANNEL_ID_RST;
            r_max_len    <= MAX_LEN_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CHANNEL_ID: r_channel_id <= pwdata;
                REG_MAX_LEN:    r_max_len    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_CHANNEL_ID: prdata = r_channel_id;
            REG_MAX_LEN:    prdata = {16'd0, r_max_len};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.channel_id = r_channel_id;
    assign o_cfg.max_len    = r_max_len;

endmodule

`default_nettype wire
